FILE: design/silu_pkg.sv
// Shared types, codes and saturation helper for the sparse ILU(0) factor block.
`default_nettype none
package silu_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_FACTOR = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_DIAG  = 2'd1;
    localparam logic [1:0] ST_ZERO_PIV = 2'd2;
    localparam logic [1:0] ST_CAP_SAT  = 2'd3;

    localparam int VAL_W   = 32;
    localparam int COL_W   = 8;
    localparam int IDX_W   = 12;
    localparam int FROW_W  = 8;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        ARITH_MUL   = 2'd0,
        ARITH_SUB   = 2'd1,
        ARITH_RECIP = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic                    start;
        arith_op_t               op;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } arith_req_t;

    typedef struct packed {
        logic                    done;
        logic                    sat;
        logic signed [VAL_W-1:0] value;
    } arith_rsp_t;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [1:0]        status;
        logic [FROW_W-1:0] fail_row;
    } result_t;

    typedef struct packed {
        logic                    sat;
        logic signed [VAL_W-1:0] value;
    } clamp_t;

    function automatic clamp_t clamp32(input logic signed [63:0] v);
        clamp_t r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r.sat   = 1'b1;
            r.value = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r.sat   = 1'b1;
            r.value = -32'sh8000_0000;
        end else begin
            r.sat   = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/silu_arith.sv
// Shared Q16.16 unit: saturating multiply, subtract and iterative reciprocal.
`default_nettype none
module silu_arith (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire silu_pkg::arith_req_t req,
    output silu_pkg::arith_rsp_t      rsp
);
    localparam int DIV_STEPS = 34;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } astate_t;

    astate_t               state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [63:0]    prod_reg, prod_next;
    logic [33:0]           quo_reg, quo_next;
    logic [34:0]           rem_reg, rem_next;
    logic [32:0]           div_reg, div_next;
    logic                  neg_reg, neg_next;
    logic                  done_reg, done_next;
    logic                  sat_reg, sat_next;
    logic signed [31:0]    res_reg, res_next;

    logic [32:0]           mag;
    logic [34:0]           rem_sh;
    logic signed [63:0]    rounded;
    logic signed [63:0]    qsigned;
    silu_pkg::clamp_t      cl;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        res_next   = res_reg;
        mag        = req.a[31] ? 33'(-{req.a[31], req.a}) : {1'b0, req.a};
        rem_sh     = {rem_reg[33:0], quo_reg[33]};
        rounded    = (prod_reg + 64'sd32768) >>> 16;
        qsigned    = neg_reg ? -$signed({30'd0, quo_reg}) : $signed({30'd0, quo_reg});
        cl         = '0;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        silu_pkg::ARITH_MUL: begin
                            prod_next  = 64'(req.a) * 64'(req.b);
                            state_next = A_MUL;
                        end
                        silu_pkg::ARITH_SUB: begin
                            cl        = silu_pkg::clamp32(64'(req.a) - 64'(req.b));
                            res_next  = cl.value;
                            sat_next  = cl.sat;
                            done_next = 1'b1;
                        end
                        silu_pkg::ARITH_RECIP: begin
                            // dividend 2^32 + |x|/2, divisor |x|
                            div_next   = mag;
                            neg_next   = req.a[31];
                            quo_next   = 34'h1_0000_0000 + 34'(mag >> 1);
                            rem_next   = '0;
                            cnt_next   = CNT_W'(DIV_STEPS);
                            state_next = A_DIV;
                        end
                        default: begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_MUL: begin
                cl         = silu_pkg::clamp32(rounded);
                res_next   = cl.value;
                sat_next   = cl.sat;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV: begin
                if (cnt_reg == '0) begin
                    cl         = silu_pkg::clamp32(qsigned);
                    res_next   = cl.value;
                    sat_next   = cl.sat;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end else begin
                    // one restoring step per cycle
                    if (rem_sh >= {2'b00, div_reg}) begin
                        rem_next = rem_sh - {2'b00, div_reg};
                        quo_next = {quo_reg[32:0], 1'b1};
                    end else begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[32:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.sat   = sat_reg;
    assign rsp.value = res_reg;
endmodule
`default_nettype wire

FILE: design/silu_core.sv
// Matrix storage and the sequencer for load, read and in-place ILU(0).
`default_nettype none
module silu_core #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_NONZEROS = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          req_type,
    input  wire logic [silu_pkg::COL_W-1:0]          col_index,
    input  wire logic [silu_pkg::VAL_W-1:0]          entry_value,
    input  wire logic                                row_end,
    input  wire logic [silu_pkg::IDX_W-1:0]          entry_index,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output silu_pkg::result_t                        res,
    output silu_pkg::arith_req_t                     arith_req,
    input  wire silu_pkg::arith_rsp_t                arith_rsp
);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NZ_W  = $clog2(MAX_NONZEROS + 1);
    localparam int NI_W  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int CW    = silu_pkg::COL_W;
    localparam int VW    = silu_pkg::VAL_W;

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001, S_READ = 24'h000002, S_RESP = 24'h000004,
        F_ROW  = 24'h000008, F_ROW1 = 24'h000010, F_ROW2 = 24'h000020,
        F_J    = 24'h000040, F_J1   = 24'h000080, F_J2   = 24'h000100,
        F_J3   = 24'h000200, F_J4   = 24'h000400, F_P    = 24'h000800,
        F_P1   = 24'h001000, F_K    = 24'h002000, F_K1   = 24'h004000,
        F_M0   = 24'h008000, F_M1   = 24'h010000, F_M2   = 24'h020000,
        F_M3   = 24'h040000, F_S    = 24'h080000, F_JEND = 24'h100000,
        F_DIAG = 24'h200000, F_D1   = 24'h400000, F_D2   = 24'h800000
    } state_t;

    // storage
    logic [CW-1:0]   col_mem  [MAX_NONZEROS];
    logic [VW-1:0]   val_mem  [MAX_NONZEROS];
    logic [NZ_W-1:0] row_mem  [MAX_ROWS + 1];
    logic [NZ_W:0]   diag_mem [MAX_ROWS];

    logic [CW-1:0]   col_rd;
    logic [VW-1:0]   val_rd;
    logic [NZ_W-1:0] row_rd;
    logic [NZ_W:0]   diag_rd;

    logic            col_we, val_we, row_we, diag_we;
    logic [NI_W-1:0] col_waddr, val_waddr, col_raddr, val_raddr;
    logic [CW-1:0]   col_wdata;
    logic [VW-1:0]   val_wdata;
    logic [ROW_W-1:0] row_waddr, row_raddr;
    logic [NZ_W-1:0] row_wdata;
    logic [RI_W-1:0] diag_waddr, diag_raddr;
    logic [NZ_W:0]   diag_wdata;

    state_t          state_reg, state_next;
    logic [ROW_W-1:0] rows_reg, rows_next, i_reg, i_next;
    logic [NZ_W-1:0] nz_reg, nz_next;
    logic            dseen_reg, dseen_next;
    logic [NZ_W-1:0] dpos_reg, dpos_next;
    logic [NZ_W-1:0] j_reg, j_next, k_reg, k_next, p_reg, p_next;
    logic [NZ_W-1:0] re_reg, re_next, pend_reg, pend_next, dpi_reg, dpi_next;
    logic [VW-1:0]   vj_reg, vj_next, d_reg, d_next, prod_reg, prod_next;
    logic [CW-1:0]   colp_reg, colp_next;
    logic            sat_reg, sat_next, hit_reg, hit_next;
    logic [1:0]      st_reg, st_next;
    logic [silu_pkg::FROW_W-1:0] fr_reg, fr_next, i_lo;
    logic [VW-1:0]   rv_reg, rv_next;
    logic            diag_hit;
    logic [NZ_W-1:0] nz_inc;

    always_comb begin
        state_next = state_reg;
        rows_next  = rows_reg;
        nz_next    = nz_reg;
        dseen_next = dseen_reg;
        dpos_next  = dpos_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        re_next    = re_reg;
        pend_next  = pend_reg;
        dpi_next   = dpi_reg;
        vj_next    = vj_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        colp_next  = colp_reg;
        hit_next   = hit_reg;
        st_next    = st_reg;
        fr_next    = fr_reg;
        rv_next    = rv_reg;
        sat_next   = sat_reg | (arith_rsp.done & arith_rsp.sat);
        i_lo       = silu_pkg::FROW_W'(32'(i_reg));
        nz_inc     = nz_reg + 1'b1;
        diag_hit   = (32'(col_index) == 32'(rows_reg)) && !dseen_reg;

        in_ready   = 1'b0;
        res_valid  = 1'b0;
        arith_req  = '0;
        col_we     = 1'b0;
        val_we     = 1'b0;
        row_we     = 1'b0;
        diag_we    = 1'b0;
        col_waddr  = NI_W'(nz_reg);
        val_waddr  = NI_W'(nz_reg);
        col_wdata  = col_index;
        val_wdata  = entry_value;
        row_waddr  = ROW_W'(32'(rows_reg) + 1);
        row_wdata  = nz_inc;
        diag_waddr = RI_W'(32'(rows_reg));
        diag_wdata = {dseen_reg | diag_hit, diag_hit ? nz_reg : dpos_reg};
        col_raddr  = NI_W'(j_reg);
        val_raddr  = NI_W'(j_reg);
        row_raddr  = ROW_W'(32'(i_reg) + 1);
        diag_raddr = RI_W'(32'(i_reg));

        case (state_reg)
            S_IDLE: begin
                in_ready  = 1'b1;
                val_raddr = NI_W'(32'(entry_index));
                if (in_valid) begin
                    st_next    = silu_pkg::ST_OK;
                    fr_next    = '0;
                    rv_next    = '0;
                    state_next = S_RESP;
                    case (req_type)
                        silu_pkg::REQ_CLEAR: begin
                            rows_next  = '0;
                            nz_next    = '0;
                            dseen_next = 1'b0;
                        end
                        silu_pkg::REQ_LOAD: begin
                            if (nz_reg == NZ_W'(MAX_NONZEROS) ||
                                rows_reg == ROW_W'(MAX_ROWS)) begin
                                // store full: drop the word
                                st_next = silu_pkg::ST_CAP_SAT;
                                fr_next = silu_pkg::FROW_W'(32'(rows_reg));
                            end else begin
                                col_we  = 1'b1;
                                val_we  = 1'b1;
                                nz_next = nz_inc;
                                if (diag_hit) begin
                                    dseen_next = 1'b1;
                                    dpos_next  = nz_reg;
                                end
                                if (row_end) begin
                                    row_we     = 1'b1;
                                    diag_we    = 1'b1;
                                    rows_next  = rows_reg + 1'b1;
                                    dseen_next = 1'b0;
                                end
                            end
                        end
                        silu_pkg::REQ_FACTOR: begin
                            i_next     = '0;
                            state_next = F_ROW;
                        end
                        silu_pkg::REQ_READ: begin
                            hit_next   = 32'(entry_index) < 32'(nz_reg);
                            state_next = S_READ;
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_READ: begin
                rv_next    = hit_reg ? val_rd : '0;
                state_next = S_RESP;
            end
            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) state_next = S_IDLE;
            end
            F_ROW: begin
                if (i_reg == rows_reg) state_next = S_RESP;
                else                   state_next = F_ROW1;
            end
            F_ROW1: begin
                row_raddr = ROW_W'(i_reg);
                if (!diag_rd[NZ_W]) begin
                    if (st_next == silu_pkg::ST_OK) begin
                        st_next = silu_pkg::ST_NO_DIAG;
                        fr_next = i_lo;
                    end
                    state_next = S_RESP;
                end else begin
                    dpi_next   = diag_rd[NZ_W-1:0];
                    re_next    = row_rd;
                    state_next = F_ROW2;
                end
            end
            F_ROW2: begin
                j_next     = (i_reg == '0) ? '0 : row_rd;
                sat_next   = 1'b0;
                state_next = F_J;
            end
            F_J: begin
                state_next = (j_reg >= re_reg) ? F_DIAG : F_J1;
            end
            F_J1: begin
                vj_next    = val_rd;
                diag_raddr = RI_W'(32'(col_rd));
                row_raddr  = ROW_W'(32'(col_rd) + 1);
                state_next = (32'(col_rd) >= 32'(i_reg)) ? F_DIAG : F_J2;
            end
            F_J2: begin
                val_raddr  = NI_W'(diag_rd[NZ_W-1:0]);
                p_next     = diag_rd[NZ_W-1:0] + 1'b1;
                pend_next  = row_rd;
                state_next = F_J3;
            end
            F_J3: begin
                arith_req.start = 1'b1;
                arith_req.op    = silu_pkg::ARITH_MUL;
                arith_req.a     = vj_reg;
                arith_req.b     = val_rd;
                state_next      = F_J4;
            end
            F_J4: begin
                if (arith_rsp.done) begin
                    d_next     = arith_rsp.value;
                    k_next     = j_reg + 1'b1;
                    state_next = F_P;
                end
            end
            F_P: begin
                col_raddr = NI_W'(p_reg);
                if (p_reg >= pend_reg || k_reg >= re_reg) state_next = F_JEND;
                else                                      state_next = F_P1;
            end
            F_P1: begin
                colp_next  = col_rd;
                state_next = F_K;
            end
            F_K: begin
                col_raddr  = NI_W'(k_reg);
                state_next = (k_reg >= re_reg) ? F_JEND : F_K1;
            end
            F_K1: begin
                if (col_rd < colp_reg) begin
                    k_next     = k_reg + 1'b1;
                    state_next = F_K;
                end else if (col_rd == colp_reg) begin
                    state_next = F_M0;
                end else begin
                    p_next     = p_reg + 1'b1;
                    state_next = F_P;
                end
            end
            F_M0: begin
                val_raddr  = NI_W'(p_reg);
                state_next = F_M1;
            end
            F_M1: begin
                arith_req.start = 1'b1;
                arith_req.op    = silu_pkg::ARITH_MUL;
                arith_req.a     = d_reg;
                arith_req.b     = val_rd;
                state_next      = F_M2;
            end
            F_M2: begin
                val_raddr = NI_W'(k_reg);
                if (arith_rsp.done) begin
                    prod_next  = arith_rsp.value;
                    state_next = F_M3;
                end
            end
            F_M3: begin
                arith_req.start = 1'b1;
                arith_req.op    = silu_pkg::ARITH_SUB;
                arith_req.a     = val_rd;
                arith_req.b     = prod_reg;
                state_next      = F_S;
            end
            F_S: begin
                if (arith_rsp.done) begin
                    val_we     = 1'b1;
                    val_waddr  = NI_W'(k_reg);
                    val_wdata  = arith_rsp.value;
                    p_next     = p_reg + 1'b1;
                    state_next = F_P;
                end
            end
            F_JEND: begin
                val_we     = 1'b1;
                val_waddr  = NI_W'(j_reg);
                val_wdata  = d_reg;
                j_next     = j_reg + 1'b1;
                state_next = F_J;
            end
            F_DIAG: begin
                val_raddr  = NI_W'(dpi_reg);
                state_next = F_D1;
            end
            F_D1: begin
                if (val_rd != '0) begin
                    arith_req.start = 1'b1;
                    arith_req.op    = silu_pkg::ARITH_RECIP;
                    arith_req.a     = val_rd;
                    state_next      = F_D2;
                end else begin
                    if (sat_reg && st_next == silu_pkg::ST_OK) begin
                        st_next = silu_pkg::ST_CAP_SAT;
                        fr_next = i_lo;
                    end
                    if (st_next == silu_pkg::ST_OK) begin
                        st_next = silu_pkg::ST_ZERO_PIV;
                        fr_next = i_lo;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = F_ROW;
                end
            end
            F_D2: begin
                if (arith_rsp.done) begin
                    val_we    = 1'b1;
                    val_waddr = NI_W'(dpi_reg);
                    val_wdata = arith_rsp.value;
                    if (sat_next && st_next == silu_pkg::ST_OK) begin
                        st_next = silu_pkg::ST_CAP_SAT;
                        fr_next = i_lo;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = F_ROW;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (col_we)  col_mem[col_waddr]   <= col_wdata;
        if (val_we)  val_mem[val_waddr]   <= val_wdata;
        if (row_we)  row_mem[row_waddr]   <= row_wdata;
        if (diag_we) diag_mem[diag_waddr] <= diag_wdata;
        col_rd  <= col_mem[col_raddr];
        val_rd  <= val_mem[val_raddr];
        row_rd  <= row_mem[row_raddr];
        diag_rd <= diag_mem[diag_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rows_reg  <= '0;
            nz_reg    <= '0;
            dseen_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            nz_reg    <= nz_next;
            dseen_reg <= dseen_next;
        end
    end

    always_ff @(posedge aclk) begin
        dpos_reg <= dpos_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        re_reg   <= re_next;
        pend_reg <= pend_next;
        dpi_reg  <= dpi_next;
        vj_reg   <= vj_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        colp_reg <= colp_next;
        hit_reg  <= hit_next;
        sat_reg  <= sat_next;
        st_reg   <= st_next;
        fr_reg   <= fr_next;
        rv_reg   <= rv_next;
    end

    assign res.read_value = rv_reg;
    assign res.status     = st_reg;
    assign res.fail_row   = fr_reg;
endmodule
`default_nettype wire

FILE: design/sparse_ilu0_factor.sv
// Top level of the sparse ILU(0) factor block: stream ports and result register.
//
// Channel  Dir  Handshake          Contents
// s_       in   s_tvalid/s_tready  tuser request kind, tlast row end, tdata entry fields
// m_       out  m_tvalid/m_tready  tdata read value, status, failing row
//
// A factor word works row by row: each multiplier is a multiply, each scanned pattern
// entry is compared, each matched update is a multiply and then a subtract, and each
// pivot is inverted by a reciprocal (34-step restoring division).
// Reset (aresetn low, synchronous) empties the matrix; the stores need no clearing.
// A stalled m_ side holds the finished word in the output register; the core waits.
`default_nettype none
module sparse_ilu0_factor #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_NONZEROS = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // col_index[7:0], entry_value[39:8], entry_index[51:40], zeros
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    input  wire logic        s_tlast,  // row_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // read_value[31:0], status[33:32], fail_row[41:34], zeros
);
    silu_pkg::result_t    res;
    silu_pkg::arith_req_t arith_req;
    silu_pkg::arith_rsp_t arith_rsp;
    logic                 res_valid, res_ready;
    logic                 m_valid_reg, m_valid_next;
    silu_pkg::result_t    m_res_reg, m_res_next;

    silu_core #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req_type    (s_tuser),
        .col_index   (s_tdata[7:0]),
        .entry_value (s_tdata[39:8]),
        .row_end     (s_tlast),
        .entry_index (s_tdata[51:40]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .arith_req   (arith_req),
        .arith_rsp   (arith_rsp)
    );

    silu_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .rsp     (arith_rsp)
    );

    // take a new result when the output slot is empty or drains this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_res_reg.fail_row, m_res_reg.status, m_res_reg.read_value};
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking stream testbench for the sparse ILU(0) factor block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int ROWS_CAP = 256;
    localparam int NNZ_CAP  = 4096;
    localparam int IDLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  col;
        logic [31:0] val;
        logic        last;
        logic [11:0] idx;
    } req_word_t;

    typedef struct packed {
        logic [31:0] rd;
        logic [1:0]  st;
        logic [7:0]  frow;
    } rsp_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    sparse_ilu0_factor uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow matrix: own copy of the compressed row storage
    int unsigned     sh_row_start [ROWS_CAP+1];
    logic [7:0]      sh_col [NNZ_CAP];
    logic signed [31:0] sh_val [NNZ_CAP];
    int unsigned     sh_diag_pos [ROWS_CAP];
    bit              sh_diag_ok [ROWS_CAP];
    int unsigned     sh_rows;
    int unsigned     sh_nnz;
    bit              sh_sat;

    req_word_t pending_words[$];
    rsp_word_t expected_words[$];

    int  mismatches = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  fail_words = 0;
    int  idle_cycles = 0;
    bit  calm_phase = 1'b0;    // no idling on either side while set
    bit  hold_start = 1'b0;    // ask the receiver for its long stall
    bit  hold_used;
    int  hold_off_left;        // long receiver stall, counted in the receiver

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sh_sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sh_sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product, round half up (floor after adding half)
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        return sat32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(64'(a) - 64'(b));
    endfunction

    function automatic logic signed [31:0] fx_recip(input logic signed [31:0] a);
        logic signed [63:0] m, q;
        m = (a < 0) ? -64'(a) : 64'(a);
        q = ((64'sd1 <<< 32) + m / 2) / m;
        return sat32((a < 0) ? -q : q);
    endfunction

    function automatic void shadow_clear();
        foreach (sh_row_start[i]) sh_row_start[i] = 0;
        foreach (sh_diag_ok[i]) sh_diag_ok[i] = 1'b0;
        sh_rows = 0;
        sh_nnz  = 0;
    endfunction

    function automatic void note_failure(inout logic [1:0] st, inout logic [7:0] fr,
                                         input logic [1:0] code, input int unsigned row);
        if (st == silu_pkg::ST_OK) begin
            st = code;
            fr = row[7:0];
        end
    endfunction

    // In-place ILU(0) over the closed rows, stopping at a row with no diagonal
    function automatic void shadow_factor(inout logic [1:0] st, inout logic [7:0] fr);
        int unsigned re, j, k, p, cj, pend, dp;
        logic signed [31:0] d;
        for (int unsigned i = 0; i < sh_rows; i++) begin
            if (!sh_diag_ok[i]) begin
                note_failure(st, fr, silu_pkg::ST_NO_DIAG, i);
                return;
            end
            re = sh_row_start[i+1];
            sh_sat = 1'b0;
            j = sh_row_start[i];
            while (j < re && sh_col[j] < i) begin
                cj = sh_col[j];
                d = fx_mul(sh_val[j], sh_val[sh_diag_pos[cj]]);
                k = j + 1;
                pend = sh_row_start[cj+1];
                p = sh_diag_pos[cj] + 1;
                while (p < pend && k < re) begin
                    while (k < re && sh_col[k] < sh_col[p]) k++;
                    if (k < re && sh_col[k] == sh_col[p])
                        sh_val[k] = fx_sub(sh_val[k], fx_mul(d, sh_val[p]));
                    p++;
                end
                sh_val[j] = d;
                j++;
            end
            dp = sh_diag_pos[i];
            if (sh_val[dp] != 0) begin
                sh_val[dp] = fx_recip(sh_val[dp]);
                if (sh_sat) note_failure(st, fr, silu_pkg::ST_CAP_SAT, i);
            end else begin
                if (sh_sat) note_failure(st, fr, silu_pkg::ST_CAP_SAT, i);
                note_failure(st, fr, silu_pkg::ST_ZERO_PIV, i);
            end
        end
    endfunction

    // Work out the response for one accepted request word
    function automatic rsp_word_t predict_response(input req_word_t w);
        rsp_word_t r;
        logic [1:0] st;
        logic [7:0] fr;
        r = '0;
        case (w.kind)
            silu_pkg::REQ_CLEAR: shadow_clear();
            silu_pkg::REQ_LOAD: begin
                if (sh_nnz >= NNZ_CAP || sh_rows >= ROWS_CAP) begin
                    r.st = silu_pkg::ST_CAP_SAT;
                    r.frow = sh_rows[7:0];
                end else begin
                    sh_col[sh_nnz] = w.col;
                    sh_val[sh_nnz] = w.val;
                    if (w.col == sh_rows && !sh_diag_ok[sh_rows]) begin
                        sh_diag_ok[sh_rows] = 1'b1;
                        sh_diag_pos[sh_rows] = sh_nnz;
                    end
                    sh_nnz++;
                    if (w.last) begin
                        sh_rows++;
                        sh_row_start[sh_rows] = sh_nnz;
                    end
                end
            end
            silu_pkg::REQ_FACTOR: begin
                st = silu_pkg::ST_OK;
                fr = 8'd0;
                shadow_factor(st, fr);
                r.st = st;
                r.frow = fr;
            end
            default: if (w.idx < sh_nnz) r.rd = sh_val[w.idx];
        endcase
        return r;
    endfunction

    function automatic req_word_t mk(input logic [1:0] kind, input logic [7:0] col,
                                     input logic [31:0] val, input logic last,
                                     input logic [11:0] idx);
        req_word_t w;
        w.kind = kind; w.col = col; w.val = val; w.last = last; w.idx = idx;
        return w;
    endfunction

    // Random noise bits in unused fields keep every input bit but tdata[55:52] toggling
    function automatic logic [31:0] rand_val(input bit tame);
        if (tame) return $urandom_range(32'h0004_0000, 32'h0000_4000) ^
                         ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
        return $urandom;
    endfunction

    function automatic req_word_t mk_noise(input logic [1:0] kind);
        return mk(kind, 8'($urandom), $urandom, 1'($urandom), 12'($urandom));
    endfunction

    // Queue one random matrix: mostly diagonally dominant banded rows
    task automatic queue_matrix(input int n, input bit broken);
        int c0, c1, dropdiag;
        pending_words.push_back(mk_noise(silu_pkg::REQ_CLEAR));
        dropdiag = broken ? int'($urandom_range(n - 1)) : -1;
        for (int r = 0; r < n; r++) begin
            c0 = (r > 2) ? r - int'($urandom_range(2)) : 0;
            c1 = r + int'($urandom_range(2));
            if (c1 > n - 1) c1 = n - 1;
            for (int c = c0; c <= c1; c++) begin
                if (c != r && $urandom_range(3) == 0) continue;
                if (c == r && r == dropdiag) continue;
                pending_words.push_back(mk(silu_pkg::REQ_LOAD, c[7:0],
                    (c == r) ? 32'h0008_0000 + $urandom_range(32'h0004_0000)
                             : rand_val(1'b1), 1'b0, 12'($urandom)));
            end
            pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'(c1 + 1 + $urandom_range(5)),
                rand_val(1'b1), 1'b1, 12'($urandom)));
        end
        pending_words.push_back(mk_noise(silu_pkg::REQ_FACTOR));
        for (int k = 0; k < 4; k++)
            pending_words.push_back(mk(silu_pkg::REQ_READ, 8'($urandom), $urandom,
                1'($urandom), 12'($urandom_range(4 * n + 4))));
    endtask

    // Driver: present the next pending word, advance on acceptance
    always @(posedge aclk) begin
        req_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= silu_pkg::REQ_CLEAR;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_words.size() > 0 && (calm_phase || $urandom_range(99) >= 31)) begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.kind;
                s_tlast  <= w.last;
                s_tdata  <= {4'h0, w.idx, w.val, w.col};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict on the input handshake
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_words.push_back(predict_response(
                mk(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tlast, s_tdata[51:40])));
            words_in++;
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin
        rsp_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                exp_w = expected_words.pop_front();
                if (exp_w.st != silu_pkg::ST_OK) fail_words++;
                if (m_tdata[31:0] !== exp_w.rd || m_tdata[33:32] !== exp_w.st ||
                    m_tdata[41:34] !== exp_w.frow || m_tdata[47:42] !== 6'h0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected rd=%h st=%0d row=%0d, got %h",
                                 words_out, exp_w.rd, exp_w.st, exp_w.frow, m_tdata);
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready      <= 1'b0;
            hold_used     <= 1'b0;
            hold_off_left <= 0;
        end else if (hold_start && !hold_used) begin
            hold_used     <= 1'b1;
            hold_off_left <= 300;
            m_tready      <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_phase || ($urandom_range(99) >= 31);
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sparse_ilu0_factor test failed");
            $finish;
        end
    end

    initial begin
        int n;
        aresetn = 1'b0;

        // Directed: read empty, zero pivot, missing diagonal, duplicate diagonal,
        // open row, saturation, refactor, extremes of each field
        pending_words.push_back(mk(silu_pkg::REQ_READ, 8'hFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF));
        pending_words.push_back(mk(silu_pkg::REQ_FACTOR, 8'd0, 32'd0, 1'b0, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd0, 32'h0001_0000, 1'b0, 12'hFFF));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd0, 32'h0002_0000, 1'b0, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd1, 32'h7FFF_FFFF, 1'b1, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd0, 32'h8000_0000, 1'b0, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd1, 32'h0000_0000, 1'b1, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd2, 32'h0000_0001, 1'b1, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd9, 32'hFFFF_FFFF, 1'b0, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_FACTOR, 8'd0, 32'd0, 1'b0, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_FACTOR, 8'd0, 32'd0, 1'b0, 12'd0));
        for (int k = 0; k < 6; k++)
            pending_words.push_back(mk(silu_pkg::REQ_READ, 8'd0, 32'd0, 1'b0, 12'(k)));
        pending_words.push_back(mk(silu_pkg::REQ_CLEAR, 8'hFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF));
        pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'd1, 32'h0001_0000, 1'b1, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_FACTOR, 8'd0, 32'd0, 1'b0, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_READ, 8'd0, 32'd0, 1'b0, 12'd0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Long receiver stall while the sender keeps offering
        @(posedge aclk);
        hold_start <= 1'b1;

        // Random matrices, mostly well-formed, small sizes
        while (pending_words.size() + words_in < 180) begin
            n = ($urandom_range(9) == 0) ? int'($urandom_range(20, 12))
                                         : int'($urandom_range(6, 1));
            queue_matrix(n, $urandom_range(7) == 0);
            if ($urandom_range(5) == 0)
                pending_words.push_back(mk_noise(silu_pkg::REQ_LOAD));
        end
        // Calm stretch: no idling on either side
        while (pending_words.size() >= 120) @(posedge aclk);
        calm_phase <= 1'b1;
        while (pending_words.size() >= 40) @(posedge aclk);
        calm_phase <= 1'b0;

        // Fill every row slot with single-entry rows, then overflow it
        while (pending_words.size() > 0) @(posedge aclk);
        pending_words.push_back(mk(silu_pkg::REQ_CLEAR, 8'd0, 32'd0, 1'b0, 12'd0));
        for (int r = 0; r < 257; r++)
            pending_words.push_back(mk(silu_pkg::REQ_LOAD, 8'(r), 32'h0001_0000, 1'b1, 12'd0));
        pending_words.push_back(mk(silu_pkg::REQ_READ, 8'd0, 32'd0, 1'b0, 12'd255));

        while (pending_words.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_words.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d request words, checked %0d result words (%0d with a failure code).",
                 words_in, words_out, fail_words);
        $display("Covered clear/load/factor/read, pivot and diagonal faults, full row store.");
        if (mismatches == 0 && expected_words.size() == 0 && words_out == words_in)
            $display("sparse_ilu0_factor test passed");
        else
            $display("sparse_ilu0_factor test failed");
        $finish;
    end

endmodule
`default_nettype wire
